[design/upc_pkg.sv]
// ----------------------------------------------------------------------------
// upc_pkg: shared types and constants for the URL percent codec
// Holds the result bundle that passes from the step logic to the response
// stage, the register map and the direction codes.
// ----------------------------------------------------------------------------
`default_nettype none

package upc_pkg;

   // Most results that one request can cause.
   localparam int MaxResults = 3;

   // Configuration register indexes.
   localparam logic REG_DIRECTION    = 1'b0;
   localparam logic REG_OUT_CAPACITY = 1'b1;

   // Direction codes.
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // Reset values of the registers.
   localparam logic        DIRECTION_RESET    = DIR_DECODE;
   localparam logic [15:0] OUT_CAPACITY_RESET = 16'hffff;

   // Results caused by one request: a count of 0 to 3 bytes, and whether the
   // final one is the string terminator.
   typedef struct packed {
      logic [1:0]            count;
      logic                  term;
      logic [2:0][7:0]       bytes;
   } upc_bundle_type;

endpackage

`default_nettype wire

[design/upc_step.sv]
// ----------------------------------------------------------------------------
// upc_step: per-request codec logic and string state
// Works out all results of one request in a single pass and keeps the escape
// state and the encode byte count, which advance when a request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module upc_step (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              in_byte,
   input  wire logic                    end_of_string,
   input  wire logic                    direction,
   input  wire logic [15:0]             out_capacity,
   output upc_pkg::upc_bundle_type      bundle
);
   import upc_pkg::*;

   localparam logic [7:0] CH_PCT = 8'h25;

   // Escape phases.
   localparam logic [1:0] PH_NONE  = 2'd0;
   localparam logic [1:0] PH_PCT   = 2'd1;
   localparam logic [1:0] PH_DIGIT = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] count_ff, count_in;

   function automatic logic is_hex(input logic [7:0] ch);
      is_hex = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h66) ||
               (ch >= 8'h41 && ch <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] ch);
      logic [7:0] v;
      if (ch >= 8'h30 && ch <= 8'h39) v = ch - 8'h30;
      else if (ch >= 8'h61 && ch <= 8'h66) v = ch - 8'h57;
      else if (ch >= 8'h41 && ch <= 8'h46) v = ch - 8'h37;
      else v = 8'h00;
      hex_val = v[3:0];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
   endfunction

   function automatic logic passes_plain(input logic [7:0] ch);
      passes_plain = (ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h61 && ch <= 8'h7a) ||
                     (ch >= 8'h41 && ch <= 8'h5a) || ch == 8'h2f || ch == 8'h5f ||
                     ch == 8'h2e || ch == 8'h2d || ch == 8'h7e;
   endfunction

   logic room;
   logic b_hex;
   logic b_pct;

   assign room  = ({1'b0, count_ff} + 17'd4) < {1'b0, out_capacity};
   assign b_hex = is_hex(in_byte);
   assign b_pct = (in_byte == CH_PCT);

   // Results and next state for the request on the ports.
   always_comb begin
      bundle   = '0;
      phase_in = phase_ff;
      held_in  = held_ff;
      count_in = count_ff;
      if (end_of_string) begin
         // Decode flushes a held escape literally before the terminator.
         bundle.term = 1'b1;
         if (direction == DIR_DECODE && phase_ff == PH_PCT) begin
            bundle.bytes[0] = CH_PCT;
            bundle.count    = 2'd2;
         end else if (direction == DIR_DECODE && phase_ff == PH_DIGIT) begin
            bundle.bytes[0] = CH_PCT;
            bundle.bytes[1] = held_ff;
            bundle.count    = 2'd3;
         end else begin
            bundle.count = 2'd1;
         end
         phase_in = PH_NONE;
         held_in  = 8'h00;
         count_in = 16'h0000;
      end else if (direction == DIR_ENCODE) begin
         // Encode: while there is room, plain bytes pass and others become a lowercase escape.
         if (room) begin
            if (passes_plain(in_byte)) begin
               bundle.bytes[0] = in_byte;
               bundle.count    = 2'd1;
               count_in        = count_ff + 16'd1;
            end else begin
               bundle.bytes[0] = CH_PCT;
               bundle.bytes[1] = hex_char(in_byte[7:4]);
               bundle.bytes[2] = hex_char(in_byte[3:0]);
               bundle.count    = 2'd3;
               count_in        = count_ff + 16'd3;
            end
         end
      end else begin
         case (phase_ff)
            PH_PCT: begin
               if (b_hex) begin
                  held_in  = in_byte;
                  phase_in = PH_DIGIT;
               end else begin
                  // Broken escape: literal '%', then the byte afresh.
                  bundle.bytes[0] = CH_PCT;
                  if (b_pct) begin
                     bundle.count = 2'd1;
                     phase_in     = PH_PCT;
                  end else begin
                     bundle.bytes[1] = in_byte;
                     bundle.count    = 2'd2;
                     phase_in        = PH_NONE;
                  end
               end
            end
            PH_DIGIT: begin
               held_in = 8'h00;
               if (b_hex) begin
                  bundle.bytes[0] = {hex_val(held_ff), hex_val(in_byte)};
                  bundle.count    = 2'd1;
                  phase_in        = PH_NONE;
               end else begin
                  // Broken escape: '%' and the held digit, then the byte afresh.
                  bundle.bytes[0] = CH_PCT;
                  bundle.bytes[1] = held_ff;
                  if (b_pct) begin
                     bundle.count = 2'd2;
                     phase_in     = PH_PCT;
                  end else begin
                     bundle.bytes[2] = in_byte;
                     bundle.count    = 2'd3;
                     phase_in        = PH_NONE;
                  end
               end
            end
            default: begin
               if (b_pct) begin
                  phase_in = PH_PCT;
               end else begin
                  bundle.bytes[0] = in_byte;
                  bundle.count    = 2'd1;
                  phase_in        = PH_NONE;
               end
            end
         endcase
      end
   end

   // String state advances on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NONE;
         held_ff  <= 8'h00;
         count_ff <= 16'h0000;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[design/upc_resp.sv]
// ----------------------------------------------------------------------------
// upc_resp: result buffering and serialisation
// A pending register takes the results of one request while a drain register
// hands out the results of the previous one, one byte per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module upc_resp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_fire,
   input  wire upc_pkg::upc_bundle_type bundle,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_is_terminator,
   output logic                         rsp_last
);
   import upc_pkg::*;

   upc_bundle_type pend_ff, drain_ff;
   logic           pend_valid_ff, pend_valid_in;
   logic           drain_valid_ff;
   logic [1:0]     idx_ff;

   logic load, drain_fire, drain_done, pend_move;

   assign load       = req_fire && (bundle.count != 2'd0);
   assign drain_fire = drain_valid_ff && rsp_ready;
   assign drain_done = drain_fire && rsp_last;
   assign pend_move  = pend_valid_ff && (!drain_valid_ff || drain_done);
   assign req_ready  = !pend_valid_ff || pend_move;

   assign pend_valid_in = pend_move ? load : (pend_valid_ff || load);

   // Output fields of the result under the drain index.
   assign rsp_valid         = drain_valid_ff;
   assign rsp_last          = (idx_ff == drain_ff.count - 2'd1);
   assign rsp_out_byte      = drain_ff.bytes[idx_ff];
   assign rsp_is_terminator = drain_ff.term && rsp_last;

   // Control state of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         drain_valid_ff <= 1'b0;
         idx_ff         <= 2'd0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (pend_move) begin
            drain_valid_ff <= 1'b1;
            idx_ff         <= 2'd0;
         end else if (drain_done) begin
            drain_valid_ff <= 1'b0;
            idx_ff         <= 2'd0;
         end else if (drain_fire) begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // Payload of both stages.
   always_ff @(posedge clock) begin
      if (load) begin
         pend_ff <= bundle;
      end
      if (pend_move) begin
         drain_ff <= pend_ff;
      end
   end

endmodule

`default_nettype wire

[design/url_percent_codec.sv]
// ----------------------------------------------------------------------------
// url_percent_codec: streaming URL percent encoder and decoder
// Takes one string byte per request and produces percent-coded bytes in the
// direction chosen by the direction register.
// ----------------------------------------------------------------------------
// Usage
//   The req_ channel carries one byte, or an end-of-string mark, per request.
//   The rsp_ channel returns zero to three bytes per request, one per cycle
//   while rsp_ready is high; rsp_last marks the final byte caused by a request,
//   and rsp_is_terminator the zero byte that closes the output string.
//   The csr_ port holds the direction (address 0) and the encode output
//   capacity (address 4); write them only while the block is idle.
// Flow
//   The first result of a request appears on rsp_ once it has passed the
//   pending and the drain registers. Results leave at one per cycle while
//   rsp_ready is high, so a request causing several results holds the output
//   until each has left, and requests with three-byte escapes are limited by
//   the single output port. Requests causing one result can be taken every
//   cycle while rsp_ready is high.
// Reset and stalls
//   Reset selects decode mode with full capacity and clears the escape state
//   and the byte count. When rsp_ready is low, the current result holds and
//   one further request's results are kept in a pending register before
//   req_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_codec (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_string,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_terminator,
   output logic             rsp_last,
   // Configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import upc_pkg::*;

   logic           direction_ff;
   logic [15:0]    capacity_ff;
   logic           csr_write;
   logic           reg_index;
   logic           req_fire;
   upc_bundle_type bundle;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[2];
   assign req_fire   = req_valid && req_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIRECTION_RESET;
         capacity_ff  <= OUT_CAPACITY_RESET;
      end else if (csr_write) begin
         if (reg_index == REG_DIRECTION) begin
            direction_ff <= csr_pwdata[0];
         end else begin
            capacity_ff <= csr_pwdata[15:0];
         end
      end
   end

   // Register read-back.
   always_comb begin
      case (reg_index)
         REG_DIRECTION:    csr_prdata = {31'h0, direction_ff};
         REG_OUT_CAPACITY: csr_prdata = {16'h0, capacity_ff};
         default:          csr_prdata = 32'h0;
      endcase
   end

   upc_step u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_fire),
      .in_byte       (req_in_byte),
      .end_of_string (req_end_of_string),
      .direction     (direction_ff),
      .out_capacity  (capacity_ff),
      .bundle        (bundle)
   );

   upc_resp u_resp (
      .clock             (clock),
      .reset             (reset),
      .req_fire          (req_fire),
      .bundle            (bundle),
      .req_ready         (req_ready),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_terminator (rsp_is_terminator),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

[design/upc_checker.sv]
// ----------------------------------------------------------------------------
// upc_checker: port-level checks for the URL percent codec
// Watches the top-level ports and flags results that break the codec's
// output rules or the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module upc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_is_terminator,
   input wire logic        rsp_last
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_is_terminator) && $stable(rsp_last))
      else $error("stalled result changed");

   // The terminator is always the final result of its request and is zero.
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_terminator |-> rsp_last && rsp_out_byte == 8'h00)
      else $error("terminator not final or not zero");

   // No result is shown in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A result that was not preceded by any request cannot appear straight out of
   // reset: after the first cycle out of reset accepts no request, the output is still empty.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result without request");

endmodule

bind url_percent_codec upc_checker u_upc_checker (.*);

`default_nettype wire
